FILE: sv/pmcb_pkg.sv
// Shared constants and types for the premultiply mip chain builder.
package pmcb_pkg;

  localparam int MAX_SIDE_LOG2_DEF = 11;
  localparam int CH_W = 8;
  localparam int SUM_CH_W = 10;
  localparam int SUM_W = 4 * SUM_CH_W;
  localparam int LEVEL_W = 4;
  localparam int POS_W = 11;

  typedef enum logic {
    REG_WIDTH_LOG2 = 1'b0,
    REG_HEIGHT_LOG2 = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [SUM_CH_W-1:0] alpha;
    logic [SUM_CH_W-1:0] blue;
    logic [SUM_CH_W-1:0] green;
    logic [SUM_CH_W-1:0] red;
  } pair_sum_t;

endpackage

FILE: sv/pmcb_premul.sv
// Alpha premultiply of one straight-alpha pixel, exact truncating divide by 255.
module pmcb_premul import pmcb_pkg::*; (
  input  pixel_t pix_in,
  output pixel_t pix_out,
  output logic   partial
);

  function automatic logic [CH_W-1:0] mul_div255(input logic [CH_W-1:0] c,
                                                 input logic [CH_W-1:0] a);
    logic [2*CH_W-1:0] p;
    logic [2*CH_W:0]   q;
    begin
      p = c * a;
      // floor(p / 255) for p up to 255*255.
      q = {1'b0, p} + {9'd0, p[2*CH_W-1:CH_W]} + 17'd1;
      mul_div255 = q[2*CH_W-1:CH_W];
    end
  endfunction

  always_comb begin
    partial = (pix_in.alpha != 8'hff);
    pix_out = pix_in;
    if (partial) begin
      pix_out.red   = mul_div255(pix_in.red, pix_in.alpha);
      pix_out.green = mul_div255(pix_in.green, pix_in.alpha);
      pix_out.blue  = mul_div255(pix_in.blue, pix_in.alpha);
    end
  end

endmodule

FILE: sv/pmcb_sum_ram.sv
// Row pair sum memory: one write port, one registered read port.
module pmcb_sum_ram import pmcb_pkg::*; #(
  parameter int ADDR_W = MAX_SIDE_LOG2_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  pair_sum_t         wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output pair_sum_t         rdata
);

  pair_sum_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/premultiply_mip_chain_builder_core.sv
// Top level of the premultiply and 2x2 box mip chain builder.
//
// Base pixels enter on the s_axis channel in raster order, one per beat, as
// straight-alpha RGBA8. Each pixel is premultiplied and emitted as level 0,
// and then walks up the mip chain: every level whose block of four completes
// with this pixel emits its averaged child pixel in turn. The m_axis channel
// carries one result per beat, tlast marks the final result caused by an
// input pixel, and tuser carries the sticky partial-alpha flag.
//
// One level is processed per cycle while the receiver accepts results, so an
// input pixel occupies the block until all of its results (1 to
// MAX_SIDE_LOG2) are handled; the pixel rate is set by the single result
// port. The pair sum read is issued one level early, so the registered read
// adds no stall. The next pixel is accepted in the same cycle that the final
// level of the current one is handled. The input pixel and each result are registered.
//
// Reset clears the level counters and the flag and restores both size
// registers to 4. The pair sum memory needs no clearing. When the receiver
// stalls, the result stays in the output register and the level walk holds;
// the input side stops taking beats once the current pixel cannot finish.
// A configuration write restarts the frame at row 0, column 0.
module premultiply_mip_chain_builder_core import pmcb_pkg::*; #(
  parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // level, col, row, out_red, out_green,
                                      // out_blue, out_alpha, zero fill
  output logic        m_axis_tuser,   // alpha_seen
  output logic        m_axis_tlast    // last
);

  localparam int LVW = (MAX_SIDE_LOG2 > 1) ? $clog2(MAX_SIDE_LOG2) : 1;
  localparam int CW = MAX_SIDE_LOG2 + 1;
  localparam int AW = MAX_SIDE_LOG2;
  localparam logic [3:0] MAX_L2 = 4'(MAX_SIDE_LOG2);

  logic [3:0] width_log2;
  logic [3:0] height_log2;
  logic       alpha_flag;

  logic [CW-1:0] col_count [MAX_SIDE_LOG2];
  logic [CW-1:0] row_count [MAX_SIDE_LOG2];
  pixel_t        pending   [MAX_SIDE_LOG2];

  logic      busy;
  logic [LVW-1:0] lv;
  pixel_t    in_pix;
  pair_sum_t pair_reg;

  // Effective sizes after clamping.
  logic [3:0] wl, hl, ml, lmax;
  always_comb begin
    wl = (width_log2 > MAX_L2) ? MAX_L2 : width_log2;
    hl = (height_log2 > MAX_L2) ? MAX_L2 : height_log2;
    ml = (wl < hl) ? wl : hl;
    lmax = (ml >= 4'd2) ? ml - 4'd1 : 4'd0;
  end

  pixel_t pre_pix;
  logic   pre_partial;
  pmcb_premul u_premul (
    .pix_in (in_pix),
    .pix_out(pre_pix),
    .partial(pre_partial)
  );

  pair_sum_t mem_q;
  logic      mem_we, mem_re;
  logic [AW-1:0] slot;
  pair_sum_t pair_new;

  pmcb_sum_ram #(.ADDR_W(AW)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(slot),
    .wdata(pair_new),
    .re   (mem_re),
    .raddr(slot),
    .rdata(mem_q)
  );

  // Per-step datapath for the level held in lv.
  logic          step_en, final_step, flag_now;
  pixel_t        px;
  logic [CW-1:0] col, row, wmask, hmask, col_inc, row_inc;
  logic [CW-1:0] base_w;
  logic [SUM_CH_W-1:0] s_r, s_g, s_b, s_a;
  logic [3:0]    lv4;

  assign step_en = busy && (!m_axis_tvalid || m_axis_tready);
  assign lv4 = 4'(lv);

  always_comb begin
    s_r = mem_q.red   + pair_reg.red;
    s_g = mem_q.green + pair_reg.green;
    s_b = mem_q.blue  + pair_reg.blue;
    s_a = mem_q.alpha + pair_reg.alpha;
    if (lv == '0) begin
      px = pre_pix;
      flag_now = alpha_flag | pre_partial;
    end else begin
      px.red   = s_r[SUM_CH_W-1:2];
      px.green = s_g[SUM_CH_W-1:2];
      px.blue  = s_b[SUM_CH_W-1:2];
      px.alpha = s_a[SUM_CH_W-1:2];
      flag_now = alpha_flag;
    end
    col = col_count[lv];
    row = row_count[lv];
    wmask = (CW'(1) << (wl - lv4)) - CW'(1);
    hmask = (CW'(1) << (hl - lv4)) - CW'(1);
    if (col == wmask) begin
      col_inc = '0;
      row_inc = (row == hmask) ? '0 : row + CW'(1);
    end else begin
      col_inc = col + CW'(1);
      row_inc = row;
    end
    final_step = (lv4 >= lmax) || !col[0] || !row[0];
    pair_new.red   = SUM_CH_W'(pending[lv].red)   + SUM_CH_W'(px.red);
    pair_new.green = SUM_CH_W'(pending[lv].green) + SUM_CH_W'(px.green);
    pair_new.blue  = SUM_CH_W'(pending[lv].blue)  + SUM_CH_W'(px.blue);
    pair_new.alpha = SUM_CH_W'(pending[lv].alpha) + SUM_CH_W'(px.alpha);
    base_w = CW'(1) << wl;
    slot = AW'(base_w - (base_w >> lv) + (col >> 1));
    mem_we = step_en && (lv4 < lmax) && col[0] && !row[0];
    mem_re = step_en && !final_step;
  end

  assign s_axis_tready = !busy || (step_en && final_step);

  // Sequencer and state.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2 <= 4'd4;
      height_log2 <= 4'd4;
      alpha_flag <= 1'b0;
      busy <= 1'b0;
      lv <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < MAX_SIDE_LOG2; i++) begin
        col_count[i] <= '0;
        row_count[i] <= '0;
      end
    end else begin
      if (step_en) begin
        m_axis_tvalid <= 1'b1;
        alpha_flag <= flag_now;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        busy <= 1'b1;
        lv <= '0;
      end else if (step_en) begin
        if (final_step) begin
          busy <= 1'b0;
        end else begin
          lv <= lv + LVW'(1);
        end
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_WIDTH_LOG2:  width_log2 <= cfg_data;
          REG_HEIGHT_LOG2: height_log2 <= cfg_data;
          default: ;
        endcase
        for (int i = 0; i < MAX_SIDE_LOG2; i++) begin
          col_count[i] <= '0;
          row_count[i] <= '0;
        end
      end else if (step_en) begin
        col_count[lv] <= col_inc;
        row_count[lv] <= row_inc;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_pix <= pixel_t'(s_axis_tdata);
    end
    if (step_en) begin
      pair_reg <= pair_new;
      if ((lv4 < lmax) && !col[0]) begin
        pending[lv] <= px;
      end
      m_axis_tdata <= {6'd0, px.alpha, px.blue, px.green, px.red,
                       POS_W'(row), POS_W'(col), lv4};
      m_axis_tuser <= flag_now;
      m_axis_tlast <= final_step;
    end
  end

endmodule
